/* src/rcs_pkg.sv */
package rcs_pkg;

  localparam int unsigned MemBytesDef = 65536;

  localparam logic [1:0] CMD_WRMEM = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_RDMEM = 2'd2;
  localparam logic [1:0] CMD_RDREG = 2'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_IDLE = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_OP     = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [31:0] UIMM_MASK = 32'hFFFFF000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [4:0]  reg_index;
  } rcs_in_t;

  typedef struct packed {
    logic [31:0] pc_value;
    logic        stopped;
    logic [31:0] read_data;
    logic [2:0]  status;
  } rcs_out_t;

  typedef enum logic [1:0] {MOP_NONE, MOP_RD, MOP_WR} rcs_mop_e;
  typedef enum logic [1:0] {SRC_CMD, SRC_PC, SRC_LS} rcs_src_e;
  typedef enum logic [1:0] {FIN_CMD, FIN_IDLE, FIN_EXEC} rcs_fin_e;

  typedef struct packed {
    logic     clr;
    logic     latch;
    logic     eng_start;
    rcs_src_e src;
    rcs_mop_e mop;
    logic     rf_rd;
    logic     rf_sel_ir;
    logic     ld_ir;
    logic     commit;
    logic     finish;
    rcs_fin_e fin;
  } rcs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic eng_last;
    logic halted;
    logic mem_load;
    logic mem_store;
  } rcs_sts_t;

endpackage

/* src/rcs_dp.sv */
module rcs_dp import rcs_pkg::*; #(
  parameter int unsigned MEM_BYTES = MemBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rcs_in_t  in_i,
  input  rcs_cmd_t cmd_i,
  output rcs_sts_t sts_o,
  output rcs_out_t res_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [31:0] rf [32];
  logic [31:0] rf_vld_q;

  logic [AW-1:0] clr_cnt_q;
  logic [1:0]    cmd_q;
  logic [31:0]   base_q, wbuf_q, acc_q, acc_d, ir_q, pc_q, rf_a_q, rf_b_q;
  logic [2:0]    nb_q, cnt_q;
  logic [7:0]    mem_rdata_q;
  logic          rok_q, halted_q;
  rcs_out_t      res_q;

  // Byte engine: one memory byte per cycle at base plus count.
  logic [31:0]   eng_addr;
  logic          eng_in;
  logic [2:0]    cnt_m1;
  logic [7:0]    rd_byte, wr_byte;
  logic          eng_we, mem_we;
  logic [AW-1:0] mem_widx;
  logic [7:0]    mem_wbyte;

  assign eng_addr = base_q + {29'b0, cnt_q};
  assign eng_in   = eng_addr < 32'(MEM_BYTES);
  assign cnt_m1   = cnt_q - 3'd1;
  assign rd_byte  = rok_q ? mem_rdata_q : 8'h00;
  assign wr_byte  = 8'(wbuf_q >> {cnt_q[1:0], 3'b000});
  assign eng_we   = (cmd_i.mop == MOP_WR) && (cnt_q < nb_q) && eng_in;
  assign mem_we   = cmd_i.clr || eng_we;
  assign mem_widx = cmd_i.clr ? clr_cnt_q : eng_addr[AW-1:0];
  assign mem_wbyte = cmd_i.clr ? 8'h00 : wr_byte;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mop == MOP_RD && cnt_q != 3'd0) begin
      acc_d = acc_q | ({24'b0, rd_byte} << {cnt_m1, 3'b000});
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wbyte;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rdata_q <= mem[eng_addr[AW-1:0]];
    rok_q       <= eng_in;
  end

  // Instruction fields and immediates.
  logic [6:0]  op, f7;
  logic [4:0]  rdn, rs1, rs2;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immu, immj, pc4;

  assign op   = ir_q[6:0];
  assign rdn  = ir_q[11:7];
  assign f3   = ir_q[14:12];
  assign rs1  = ir_q[19:15];
  assign rs2  = ir_q[24:20];
  assign f7   = ir_q[31:25];
  assign immi = {{20{ir_q[31]}}, ir_q[31:20]};
  assign imms = {{20{ir_q[31]}}, ir_q[31:25], ir_q[11:7]};
  assign immb = {{19{ir_q[31]}}, ir_q[31], ir_q[7], ir_q[30:25], ir_q[11:8], 1'b0};
  assign immu = ir_q & UIMM_MASK;
  assign immj = {{11{ir_q[31]}}, ir_q[31], ir_q[19:12], ir_q[20], ir_q[30:21], 1'b0};
  assign pc4  = pc_q + 32'd4;

  logic [31:0] alu_b, alu_y, ld_val;
  logic [4:0]  shamt;

  assign alu_b = (op == OP_OP) ? rf_b_q : immi;
  assign shamt = alu_b[4:0];

  always_comb begin
    case (f3)
      3'd0: alu_y = (op == OP_OP && f7 == F7_ALT) ? rf_a_q - alu_b : rf_a_q + alu_b;
      3'd1: alu_y = rf_a_q << shamt;
      3'd2: alu_y = {31'b0, $signed(rf_a_q) < $signed(alu_b)};
      3'd3: alu_y = {31'b0, rf_a_q < alu_b};
      3'd4: alu_y = rf_a_q ^ alu_b;
      3'd5: alu_y = (f7 == F7_ALT) ? 32'($signed(rf_a_q) >>> shamt) : rf_a_q >> shamt;
      3'd6: alu_y = rf_a_q | alu_b;
      default: alu_y = rf_a_q & alu_b;
    endcase
  end

  always_comb begin
    case (f3)
      3'd0: ld_val = {{24{acc_q[7]}}, acc_q[7:0]};
      3'd1: ld_val = {{16{acc_q[15]}}, acc_q[15:0]};
      3'd4: ld_val = {24'b0, acc_q[7:0]};
      3'd5: ld_val = {16'b0, acc_q[15:0]};
      default: ld_val = acc_q;
    endcase
  end

  logic        wr_en, ls_ok, taken, halt_nxt;
  logic [31:0] wr_val, pc_nxt;
  logic [2:0]  ex_st;

  always_comb begin
    wr_en    = 1'b0;
    wr_val   = alu_y;
    pc_nxt   = pc4;
    halt_nxt = halted_q;
    ex_st    = ST_OK;
    ls_ok    = 1'b0;
    taken    = 1'b0;
    case (op)
      OP_LOAD: begin
        ls_ok  = (f3 != 3'd3) && (f3 != 3'd6) && (f3 != 3'd7);
        wr_en  = ls_ok;
        wr_val = ld_val;
        if (!ls_ok) ex_st = ST_SKIP;
      end
      OP_IMM, OP_OP: begin
        wr_en = 1'b1;
      end
      OP_AUIPC: begin
        wr_en  = 1'b1;
        wr_val = pc_q + immu;
      end
      OP_LUI: begin
        wr_en  = 1'b1;
        wr_val = immu;
      end
      OP_STORE: begin
        ls_ok = f3 < 3'd3;
        if (!ls_ok) ex_st = ST_SKIP;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: taken = rf_a_q == rf_b_q;
          3'd1: taken = rf_a_q != rf_b_q;
          3'd4: taken = $signed(rf_a_q) < $signed(rf_b_q);
          3'd5: taken = $signed(rf_a_q) >= $signed(rf_b_q);
          3'd6: taken = rf_a_q < rf_b_q;
          3'd7: taken = rf_a_q >= rf_b_q;
          default: ex_st = ST_SKIP;
        endcase
        if (taken) pc_nxt = pc_q + immb;
      end
      OP_JALR: begin
        wr_en  = 1'b1;
        wr_val = pc4;
        pc_nxt = (rf_a_q + immi) & ~32'd1;
      end
      OP_JAL: begin
        wr_en  = 1'b1;
        wr_val = pc4;
        pc_nxt = pc_q + immj;
      end
      default: begin
        pc_nxt   = pc_q;
        halt_nxt = 1'b1;
        ex_st    = ST_HALT;
      end
    endcase
  end

  logic [31:0] ls_ea;
  logic [2:0]  ls_nb;
  assign ls_ea = rf_a_q + ((op == OP_STORE) ? imms : immi);
  assign ls_nb = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      pc_q      <= '0;
      halted_q  <= 1'b0;
      cnt_q     <= '0;
      nb_q      <= '0;
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.commit) begin
        pc_q     <= pc_nxt;
        halted_q <= halt_nxt;
      end
      if (cmd_i.eng_start) begin
        cnt_q <= '0;
        nb_q  <= (cmd_i.src == SRC_LS) ? ls_nb : 3'd4;
      end else if (cmd_i.mop != MOP_NONE && cnt_q != nb_q) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) cmd_q <= in_i.opcode;
    if (cmd_i.eng_start) begin
      acc_q <= '0;
      case (cmd_i.src)
        SRC_CMD: begin
          base_q <= in_i.address;
          wbuf_q <= in_i.write_data;
        end
        SRC_PC: begin
          base_q <= pc_q;
          wbuf_q <= '0;
        end
        default: begin
          base_q <= ls_ea;
          wbuf_q <= rf_b_q;
        end
      endcase
    end else begin
      acc_q <= acc_d;
    end
    if (cmd_i.ld_ir) ir_q <= acc_q;
  end

  // Register file: two registered read ports, one write port.
  logic [4:0] ra, rb;
  assign ra = cmd_i.rf_sel_ir ? acc_q[19:15] : in_i.reg_index;
  assign rb = acc_q[24:20];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rf_rd) begin
      rf_a_q <= (ra != 5'd0 && rf_vld_q[ra]) ? rf[ra] : 32'd0;
      rf_b_q <= (rb != 5'd0 && rf_vld_q[rb]) ? rf[rb] : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) rf[rdn] <= wr_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (cmd_i.commit && wr_en && rdn != 5'd0) begin
      rf_vld_q[rdn] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      case (cmd_i.fin)
        FIN_EXEC: begin
          res_q.pc_value  <= pc_nxt;
          res_q.stopped   <= halt_nxt;
          res_q.read_data <= '0;
          res_q.status    <= ex_st;
        end
        FIN_IDLE: begin
          res_q.pc_value  <= pc_q;
          res_q.stopped   <= halted_q;
          res_q.read_data <= '0;
          res_q.status    <= ST_IDLE;
        end
        default: begin
          res_q.pc_value  <= pc_q;
          res_q.stopped   <= halted_q;
          res_q.read_data <= (cmd_q == CMD_RDMEM) ? acc_d :
                             (cmd_q == CMD_RDREG) ? rf_a_q : 32'd0;
          res_q.status    <= ST_DONE;
        end
      endcase
    end
  end

  assign res_o = res_q;

  assign sts_o.clr_last  = clr_cnt_q == AW'(MEM_BYTES - 1);
  assign sts_o.eng_last  = cnt_q == nb_q;
  assign sts_o.halted    = halted_q;
  assign sts_o.mem_load  = (op == OP_LOAD) && ls_ok;
  assign sts_o.mem_store = (op == OP_STORE) && ls_ok;

endmodule

/* src/rcs_ctrl.sv */
module rcs_ctrl import rcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] opcode_i,
  input  rcs_sts_t   sts_i,
  output rcs_cmd_t   cmd_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WR, S_RD, S_RREG, S_FETCH, S_DEC, S_EXEC, S_LD, S_LWB, S_ST
  } state_e;

  state_e   state_q, state_d;
  logic     done_q;
  rcs_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          case (opcode_i)
            CMD_WRMEM: begin
              cmd.eng_start = 1'b1;
              cmd.src       = SRC_CMD;
              state_d       = S_WR;
            end
            CMD_RDMEM: begin
              cmd.eng_start = 1'b1;
              cmd.src       = SRC_CMD;
              state_d       = S_RD;
            end
            CMD_RDREG: begin
              cmd.rf_rd = 1'b1;
              state_d   = S_RREG;
            end
            default: begin
              if (sts_i.halted) begin
                cmd.finish = 1'b1;
                cmd.fin    = FIN_IDLE;
              end else begin
                cmd.eng_start = 1'b1;
                cmd.src       = SRC_PC;
                state_d       = S_FETCH;
              end
            end
          endcase
        end
      end
      S_WR, S_RD: begin
        cmd.mop = (state_q == S_WR) ? MOP_WR : MOP_RD;
        if (sts_i.eng_last) begin
          cmd.finish = 1'b1;
          cmd.fin    = FIN_CMD;
          state_d    = S_IDLE;
        end
      end
      S_RREG: begin
        cmd.finish = 1'b1;
        cmd.fin    = FIN_CMD;
        state_d    = S_IDLE;
      end
      S_FETCH: begin
        cmd.mop = MOP_RD;
        if (sts_i.eng_last) state_d = S_DEC;
      end
      S_DEC: begin
        cmd.ld_ir     = 1'b1;
        cmd.rf_rd     = 1'b1;
        cmd.rf_sel_ir = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.mem_load || sts_i.mem_store) begin
          cmd.eng_start = 1'b1;
          cmd.src       = SRC_LS;
          state_d       = sts_i.mem_load ? S_LD : S_ST;
        end else begin
          cmd.commit = 1'b1;
          cmd.finish = 1'b1;
          cmd.fin    = FIN_EXEC;
          state_d    = S_IDLE;
        end
      end
      S_LD: begin
        cmd.mop = MOP_RD;
        if (sts_i.eng_last) state_d = S_LWB;
      end
      S_LWB: begin
        cmd.commit = 1'b1;
        cmd.finish = 1'b1;
        cmd.fin    = FIN_EXEC;
        state_d    = S_IDLE;
      end
      S_ST: begin
        cmd.mop = MOP_WR;
        if (sts_i.eng_last) begin
          cmd.commit = 1'b1;
          cmd.finish = 1'b1;
          cmd.fin    = FIN_EXEC;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd.finish;
    end
  end

  assign cmd_o  = cmd;
  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result strobe outside idle");
  a_no_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !done_q) else $error("result during clearing pass");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start && opcode_i != CMD_STEP) |=> busy)
    else $error("command not taken up");
  a_one_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(cmd.commit && state_q != S_IDLE)) else $error("commit after finish");
`endif

endmodule

/* src/rv32i_core_step.sv */
// A register read strobes its item via state S_RREG and the done register; a memory word
// read or write moves one byte per cycle. Step: 4-byte fetch, decode, execute; loads and
// stores then move 1, 2 or 4 bytes by width, and loads add a write-back state.
// Step while halted strobes in the next cycle. One item at a time: the next one is taken
// at the edge that ends the strobe, and results cannot be stalled. After reset the block
// stays busy while it clears every byte of the memory.
module rv32i_core_step import rcs_pkg::*; #(
  parameter int unsigned MEM_BYTES = MemBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rcs_in_t  in_i,
  output logic     done_o,
  output rcs_out_t res_o
);

  rcs_cmd_t cmd;
  rcs_sts_t sts;

  rcs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (in_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  rcs_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o)
  );

endmodule
